### src/assert_macros.svh
// Assertion macros included by the RTL of the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### src/utf8d_pkg.sv
// Types and constants of the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned ErrWidth   = 3;
  localparam int unsigned LenWidth   = 3;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrWidth   = $clog2(FifoDepth);
  localparam int unsigned CntWidth   = $clog2(FifoDepth + 1);

  localparam logic [CpWidth-1:0] ReplChar    = 21'h00FFFD;
  localparam logic [CpWidth-1:0] MaxScalar   = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrLow     = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHigh    = 21'h00DFFF;
  localparam logic [CpWidth-1:0] Floor2Byte  = 21'h00007F;
  localparam logic [CpWidth-1:0] Floor3Byte  = 21'h0007FF;
  localparam logic [CpWidth-1:0] Floor4Byte  = 21'h00FFFF;

  // Error codes carried in error_code and in both sticky registers.
  typedef enum logic [ErrWidth-1:0] {
    ErrNone       = 3'd0,
    ErrUnexpCont  = 3'd1,
    ErrMissCont   = 3'd2,
    ErrInvalid    = 3'd3,
    ErrOverlong   = 3'd4,
    ErrSurrogate  = 3'd5,
    ErrAboveRange = 3'd6
  } err_e;

  // One result beat as held in the output queue.
  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    err_e                error_code;
    logic [LenWidth-1:0] seq_length;
    err_e                sticky_error;
    err_e                sticky_structural;
    logic                last_of_run;
  } res_t;

endpackage

### src/utf8_stream_decoder_core.sv
// UTF-8 stream decoder: one byte per beat in, decoded code points out.
//
// Accepts one byte per clock cycle while in_stall_o is low. The byte is
// decoded in the cycle it is accepted, against the registered partial
// sequence, and its results (zero, one or two) are written into a four-entry
// output queue, which presents one result per cycle while out_stall_i is
// low. A byte that interrupts a pending sequence without opening a new one
// gives two results, so the sustained output rate of one result per cycle is
// what bounds throughput on such streams. in_stall_o is high while fewer
// than two queue entries are free. The queue head drives the output port.
module utf8_stream_decoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           flush_i,
  input  logic                           clear_errors_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [utf8d_pkg::CpWidth-1:0]  code_point_o,
  output logic [utf8d_pkg::ErrWidth-1:0] error_code_o,
  output logic [utf8d_pkg::LenWidth-1:0] seq_length_o,
  output logic [utf8d_pkg::ErrWidth-1:0] sticky_error_o,
  output logic [utf8d_pkg::ErrWidth-1:0] sticky_structural_o,
  output logic                           last_of_run_o
);
  import utf8d_pkg::*;
  `include "assert_macros.svh"

  // Decoder state.
  logic [CpWidth-1:0]  pv_q, pv_d;
  logic [1:0]          rem_q, rem_d;
  logic [LenWidth-1:0] len_q, len_d;
  err_e                eh_q, eh_d;
  err_e                sh_q, sh_d;

  // Output queue.
  res_t                fifo_q [FifoDepth];
  logic [PtrWidth-1:0] wr_q, rd_q;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  logic in_acc, out_acc;
  logic pending, is_cont;

  // Lead byte decode.
  logic                s_emit;
  logic [CpWidth-1:0]  s_cp;
  err_e                s_err;
  logic                s_open;
  logic [CpWidth-1:0]  s_pv;
  logic [1:0]          s_rem;

  // Continuation byte decode.
  logic [CpWidth-1:0]  c_cp_full;
  logic [LenWidth-1:0] c_len;
  logic [CpWidth-1:0]  c_floor;
  logic [CpWidth-1:0]  c_cp;
  err_e                c_err;

  // Results of this beat.
  res_t                res_a, res_b;
  logic                have_a, have_b;
  err_e                eh_base, sh_base, eh_a, sh_a, eh_b, sh_b;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign in_stall_o = cnt_q > CntWidth'(FifoDepth - 2);
  assign out_valid_o = cnt_q != '0;

  assign pending = rem_q != 2'd0;
  assign is_cont = data_byte_i[7:6] == 2'b10;

  // Decode a byte that starts a new sequence.
  always_comb begin
    s_emit = 1'b0;
    s_cp   = ReplChar;
    s_err  = ErrNone;
    s_open = 1'b0;
    s_pv   = '0;
    s_rem  = 2'd0;
    if (!data_byte_i[7]) begin
      s_emit = 1'b1;
      s_cp   = CpWidth'(data_byte_i);
    end else if (data_byte_i[6] == 1'b0) begin
      s_emit = 1'b1;
      s_err  = ErrUnexpCont;
    end else if (data_byte_i[5] == 1'b0) begin
      s_open = 1'b1;
      s_pv   = CpWidth'(data_byte_i[4:0]);
      s_rem  = 2'd1;
    end else if (data_byte_i[4] == 1'b0) begin
      s_open = 1'b1;
      s_pv   = CpWidth'(data_byte_i[3:0]);
      s_rem  = 2'd2;
    end else if (data_byte_i[3] == 1'b0) begin
      s_open = 1'b1;
      s_pv   = CpWidth'(data_byte_i[2:0]);
      s_rem  = 2'd3;
    end else begin
      s_emit = 1'b1;
      s_err  = ErrInvalid;
    end
  end

  // Fold in a continuation byte and range check the finished value.
  always_comb begin
    c_cp_full = {pv_q[CpWidth-7:0], data_byte_i[5:0]};
    c_len     = len_q + LenWidth'(1);
    case (c_len)
      3'd2:    c_floor = Floor2Byte;
      3'd3:    c_floor = Floor3Byte;
      default: c_floor = Floor4Byte;
    endcase
    c_cp = c_cp_full;
    if (c_cp_full <= c_floor) begin
      c_err = ErrOverlong;
    end else if (c_cp_full < SurrLow) begin
      c_err = ErrNone;
    end else if (c_cp_full <= SurrHigh) begin
      c_err = ErrSurrogate;
    end else if (c_cp_full <= MaxScalar) begin
      c_err = ErrNone;
    end else begin
      c_err = ErrAboveRange;
      c_cp  = ReplChar;
    end
  end

  // Compose the results of this beat and the next decoder state.
  always_comb begin
    have_a = 1'b0;
    have_b = 1'b0;
    res_a  = '0;
    res_b  = '0;
    pv_d   = pv_q;
    rem_d  = rem_q;
    len_d  = len_q;

    if (flush_i) begin
      if (pending) begin
        have_a           = 1'b1;
        res_a.code_point = ReplChar;
        res_a.error_code = ErrMissCont;
        res_a.seq_length = len_q;
        pv_d  = '0;
        rem_d = 2'd0;
        len_d = '0;
      end
    end else if (pending && is_cont) begin
      if (rem_q == 2'd1) begin
        have_a           = 1'b1;
        res_a.code_point = c_cp;
        res_a.error_code = c_err;
        res_a.seq_length = c_len;
        pv_d  = '0;
        rem_d = 2'd0;
        len_d = '0;
      end else begin
        pv_d  = c_cp_full;
        rem_d = rem_q - 2'd1;
        len_d = c_len;
      end
    end else begin
      // Idle start, or an interrupted sequence followed by a fresh start.
      if (pending) begin
        have_a           = 1'b1;
        res_a.code_point = ReplChar;
        res_a.error_code = ErrMissCont;
        res_a.seq_length = len_q;
        have_b           = s_emit;
        res_b.code_point = s_cp;
        res_b.error_code = s_err;
        res_b.seq_length = LenWidth'(1);
      end else begin
        have_a           = s_emit;
        res_a.code_point = s_cp;
        res_a.error_code = s_err;
        res_a.seq_length = LenWidth'(1);
      end
      pv_d  = s_pv;
      rem_d = s_rem;
      len_d = s_open ? LenWidth'(1) : '0;
    end

    // Sticky registers are updated in result order.
    eh_base = clear_errors_i ? ErrNone : eh_q;
    sh_base = clear_errors_i ? ErrNone : sh_q;
    eh_a = eh_base;
    sh_a = sh_base;
    if (have_a && res_a.error_code != ErrNone) begin
      eh_a = res_a.error_code;
      if (res_a.error_code != ErrOverlong && res_a.error_code != ErrSurrogate) begin
        sh_a = res_a.error_code;
      end
    end
    eh_b = eh_a;
    sh_b = sh_a;
    if (have_b && res_b.error_code != ErrNone) begin
      eh_b = res_b.error_code;
      if (res_b.error_code != ErrOverlong && res_b.error_code != ErrSurrogate) begin
        sh_b = res_b.error_code;
      end
    end
    res_a.sticky_error      = eh_a;
    res_a.sticky_structural = sh_a;
    res_a.last_of_run       = !have_b;
    res_b.sticky_error      = eh_b;
    res_b.sticky_structural = sh_b;
    res_b.last_of_run       = 1'b1;
    eh_d = eh_b;
    sh_d = sh_b;
  end

  // Queue occupancy after this cycle's pushes and pop.
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = cnt_d + CntWidth'(have_a) + CntWidth'(have_b);
    end
    if (out_acc) begin
      cnt_d = cnt_d - CntWidth'(1);
    end
  end

  // Control and decoder state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      rem_q <= 2'd0;
      len_q <= '0;
      eh_q  <= ErrNone;
      sh_q  <= ErrNone;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        pv_q  <= pv_d;
        rem_q <= rem_d;
        len_q <= len_d;
        eh_q  <= eh_d;
        sh_q  <= sh_d;
        wr_q  <= wr_q + PtrWidth'(have_a) + PtrWidth'(have_b);
      end
      if (out_acc) begin
        rd_q <= rd_q + PtrWidth'(1);
      end
    end
  end

  // Queue payload; the second result lands right behind the first.
  always_ff @(posedge clk_i) begin
    if (in_acc && have_a) begin
      fifo_q[wr_q] <= res_a;
    end
    if (in_acc && have_b) begin
      fifo_q[wr_q + PtrWidth'(1)] <= res_b;
    end
  end

  // Head of the queue drives the result port.
  assign code_point_o        = fifo_q[rd_q].code_point;
  assign error_code_o        = fifo_q[rd_q].error_code;
  assign seq_length_o        = fifo_q[rd_q].seq_length;
  assign sticky_error_o      = fifo_q[rd_q].sticky_error;
  assign sticky_structural_o = fifo_q[rd_q].sticky_structural;
  assign last_of_run_o       = fifo_q[rd_q].last_of_run;

  // Checks on the decoder state and the queue.
  `ASSERT_AT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntWidth'(FifoDepth), "queue overfilled")
  `ASSERT_AT(a_pend_len, clk_i, rst_ni, (rem_q == 2'd0) == (len_q == '0), "pending state split")
  `ASSERT_AT(a_seq_total, clk_i, rst_ni, ({1'b0, len_q} + 4'(rem_q)) <= 4'd4, "sequence too long")
  `ASSERT_IMPL(a_pair_kept, clk_i, rst_ni, out_acc && !last_of_run_o, cnt_q >= CntWidth'(2), "second result of a beat missing")
  `ASSERT_IMPL(a_sticky_order, clk_i, rst_ni, out_valid_o && sticky_structural_o != ErrNone, sticky_error_o != ErrNone, "sticky registers disagree")

endmodule
